@@ hdl/turbo_encoder_rsc16_terminated_defines.svh @@
// ----------------------------------------------------------------------------
// Turbo encoder assertion macros
// Shared property forms for the port checker of the turbo encoder.
// ----------------------------------------------------------------------------
`ifndef TURBO_ENCODER_RSC16_TERMINATED_DEFINES_SVH
`define TURBO_ENCODER_RSC16_TERMINATED_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TE16_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TE16_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TE16_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/te16_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// te16_pkg
// Types, constants and encoder step functions of the turbo encoder.
// ----------------------------------------------------------------------------
package te16_pkg;

  // Sizes fixed by the item and register formats.
  localparam int unsigned BLOCK_MAX_DEF = 128;
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned STATE_W       = 4;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned ENC_MEMORY    = 4;

  localparam logic [COUNT_W-1:0] LEN_RESET = 8'd128;

  // Input item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_MSG  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LENGTH = 1'b0,
    CFG_TERMINATE    = 1'b1
  } cfg_index_t;

  // Result item kinds.
  typedef enum logic {
    KIND_PARITY1 = 1'b0,
    KIND_PARITY2 = 1'b1
  } kind_t;

  // Item handed from the front stage to the output stage.
  typedef struct packed {
    kind_t kind;
    logic  data_bit;
    logic  parity_bit;
    logic  block_end;
  } stage_t;

  // Parity 1+D^2+D^3+D^4 of one encoder step.
  function automatic logic rsc_parity(input logic [STATE_W-1:0] s, input logic u);
    rsc_parity = u ^ s[0] ^ s[1] ^ s[2];
  endfunction

  // Next state with feedback 1+D+D^4.
  function automatic logic [STATE_W-1:0] rsc_next(input logic [STATE_W-1:0] s,
                                                  input logic u);
    rsc_next = {s[STATE_W-2:0], u ^ s[0] ^ s[3]};
  endfunction

endpackage

@@ hdl/te16_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// te16_in_if
// Input channel of the turbo encoder: valid, ready and one input item.
// ----------------------------------------------------------------------------
interface te16_in_if;
  logic                          valid;
  logic                          ready;
  logic [te16_pkg::MODE_W-1:0]   mode;
  logic [te16_pkg::POS_W-1:0]    source_position;
  logic [te16_pkg::POS_W-1:0]    target_position;
  logic                          message_bit;

  modport source (output valid, mode, source_position, target_position, message_bit,
                  input ready);
  modport sink   (input valid, mode, source_position, target_position, message_bit,
                  output ready);
endinterface

@@ hdl/te16_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// te16_out_if
// Result channel of the turbo encoder: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface te16_out_if;
  logic valid;
  logic ready;
  logic kind;
  logic systematic_bit;
  logic parity_bit;
  logic block_end;

  modport source (output valid, kind, systematic_bit, parity_bit, block_end,
                  input ready);
  modport sink   (input valid, kind, systematic_bit, parity_bit, block_end,
                  output ready);
endinterface

@@ hdl/turbo_encoder_rsc16_terminated.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turbo_encoder_rsc16_terminated
// Rate one-third turbo encoder with two 16-state recursive systematic
// encoders and a loadable interleaver.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Carries
//  feed     in         valid / ready      mode, positions, message bit
//  result   out        valid / ready      kind, systematic, parity, block end
//  cfg      in         write enable only  block length, termination enable
//
// One item is accepted per clock cycle while feed.ready is high. Its result
// passes through the stage register and then the result register. Load items
// and mode three items give no result.
// Encoder two runs in the output stage, so the interleaved bit is read into
// the stage register ahead of its use.
// Reset is synchronous and clears control state only; the stores need none.
// When the result is stalled the output register holds it, and feed.ready
// falls only once the input stage is full as well.
//
module turbo_encoder_rsc16_terminated #(
  parameter int unsigned BLOCK_MAX = te16_pkg::BLOCK_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  te16_in_if.sink                          feed,
  te16_out_if.source                       result,
  input  logic                             cfg_we,
  input  logic [te16_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [te16_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic             stage_valid;
  logic             stage_ready;
  te16_pkg::stage_t stage;

  // Input stage with encoder one and the stores.
  te16_front #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .feed        (feed),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage)
  );

  // Output stage with encoder two.
  te16_back u_back (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_ready (stage_ready),
    .stage       (stage),
    .result      (result)
  );

endmodule

@@ hdl/te16_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// te16_front
// Input stage: configuration, bit counters, encoder one, the permutation
// table and the interleaved bit store.
// ----------------------------------------------------------------------------
module te16_front #(
  parameter int unsigned BLOCK_MAX = te16_pkg::BLOCK_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  te16_in_if.sink                            feed,
  input  logic                               cfg_we,
  input  logic [te16_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [te16_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               stage_valid,
  input  logic                               stage_ready,
  output te16_pkg::stage_t                   stage
);

  localparam int unsigned CW      = te16_pkg::COUNT_W;
  localparam int unsigned PW      = te16_pkg::POS_W;
  localparam int unsigned SW      = te16_pkg::STATE_W;
  // Only positions reachable through the 7-bit fields need storage.
  localparam int unsigned POS_SPAN = 1 << PW;
  localparam int unsigned DEPTH   = (BLOCK_MAX < POS_SPAN) ? BLOCK_MAX : POS_SPAN;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned LEN_TOP = (1 << CW) - 1;
  localparam int unsigned LEN_CAP = (BLOCK_MAX < LEN_TOP) ? BLOCK_MAX : LEN_TOP;
  localparam logic [CW-1:0] LEN_CAP_V = CW'(LEN_CAP);
  localparam logic [CW-1:0] DEPTH_V   = CW'(DEPTH);
  localparam logic [CW:0]   MEM_V     = (CW + 1)'(te16_pkg::ENC_MEMORY);

  // Configuration registers.
  logic [CW-1:0] block_length;
  logic          terminate_enable;

  // Encoder one and the two position counters.
  logic [SW-1:0] enc1_state;
  logic [CW-1:0] input_count;
  logic [CW-1:0] readout_count;

  // Stores.
  logic [PW-1:0] perm_mem [DEPTH];
  logic          ilv_mem  [DEPTH];

  // Stage register.
  logic                  s1_valid;
  te16_pkg::kind_t       s1_kind;
  logic                  s1_sys;
  logic                  s1_par;
  logic                  s1_end;
  logic                  s1_wr_ok;
  logic [PW-1:0]         s1_tgt;
  logic                  s1_ilv;
  logic                  s1_hit;
  logic                  s1_hit_bit;

  logic [CW-1:0] len_sat;
  logic [CW-1:0] len_eff;
  logic          end1;
  logic          end2;
  logic          force_bit;
  logic          enc_bit;
  logic          accept;
  logic          s1_fire;
  logic          ilv_we;
  logic [AW-1:0] ilv_waddr;
  logic [AW-1:0] rd_addr;
  logic          load_ok;

  // Effective block length: saturated to BLOCK_MAX and the 8-bit range, zero acts as one.
  always_comb begin
    len_sat = (block_length > LEN_CAP_V) ? LEN_CAP_V : block_length;
    len_eff = (len_sat == '0) ? CW'(1) : len_sat;
  end

  // Block end tests and the termination bit of encoder one.
  always_comb begin
    end1      = (({1'b0, input_count} + (CW + 1)'(1)) >= {1'b0, len_eff});
    end2      = (({1'b0, readout_count} + (CW + 1)'(1)) >= {1'b0, len_eff});
    force_bit = terminate_enable && (({1'b0, input_count} + MEM_V) >= {1'b0, len_eff});
    enc_bit   = force_bit ? (enc1_state[0] ^ enc1_state[3]) : feed.message_bit;
  end

  // Handshake: a new item enters whenever the stage is free or moving on.
  assign feed.ready = !s1_valid || stage_ready;
  assign accept     = feed.valid && feed.ready;
  assign s1_fire    = s1_valid && stage_ready;
  assign load_ok    = ({1'b0, feed.source_position} < DEPTH_V);
  assign rd_addr    = readout_count[AW-1:0];

  // A message bit is stored at its interleaved position as it leaves the stage.
  assign ilv_we    = s1_fire && (s1_kind == te16_pkg::KIND_PARITY1) && s1_wr_ok &&
                     ({1'b0, s1_tgt} < DEPTH_V);
  assign ilv_waddr = s1_tgt[AW-1:0];

  // Configuration, encoder one and the counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length     <= te16_pkg::LEN_RESET;
      terminate_enable <= 1'b1;
      enc1_state       <= '0;
      input_count      <= '0;
      readout_count    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          te16_pkg::CFG_BLOCK_LENGTH: block_length     <= cfg_data;
          te16_pkg::CFG_TERMINATE:    terminate_enable <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        unique case (feed.mode)
          te16_pkg::MODE_MSG: begin
            enc1_state  <= end1 ? '0 : te16_pkg::rsc_next(enc1_state, enc_bit);
            input_count <= end1 ? '0 : CW'({1'b0, input_count} + (CW + 1)'(1));
          end
          te16_pkg::MODE_READ: begin
            readout_count <= end2 ? '0 : CW'({1'b0, readout_count} + (CW + 1)'(1));
          end
          default: ;
        endcase
      end
    end
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed.ready) begin
      s1_valid <= accept && ((feed.mode == te16_pkg::MODE_MSG) ||
                             (feed.mode == te16_pkg::MODE_READ));
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (feed.mode == te16_pkg::MODE_READ) begin
        s1_kind <= te16_pkg::KIND_PARITY2;
        s1_end  <= end2;
      end else begin
        s1_kind <= te16_pkg::KIND_PARITY1;
        s1_end  <= end1;
      end
      s1_sys   <= enc_bit;
      s1_par   <= te16_pkg::rsc_parity(enc1_state, enc_bit);
      s1_wr_ok <= (input_count < DEPTH_V);
    end
  end

  // Permutation table: written by load items, read at the message position.
  always_ff @(posedge clk) begin
    if (accept && (feed.mode == te16_pkg::MODE_LOAD) && load_ok) begin
      perm_mem[feed.source_position[AW-1:0]] <= feed.target_position;
    end
    if (accept) begin
      s1_tgt <= perm_mem[input_count[AW-1:0]];
    end
  end

  // Interleaved bit store, with a bypass for a read that meets a write.
  always_ff @(posedge clk) begin
    if (ilv_we) begin
      ilv_mem[ilv_waddr] <= s1_sys;
    end
    if (accept) begin
      s1_ilv     <= ilv_mem[rd_addr];
      s1_hit     <= ilv_we && (ilv_waddr == rd_addr);
      s1_hit_bit <= s1_sys;
    end
  end

  // Item handed to the output stage.
  always_comb begin
    stage.kind       = s1_kind;
    stage.data_bit   = (s1_kind == te16_pkg::KIND_PARITY2) ?
                       (s1_hit ? s1_hit_bit : s1_ilv) : s1_sys;
    stage.parity_bit = s1_par;
    stage.block_end  = s1_end;
  end

  assign stage_valid = s1_valid;

endmodule

@@ hdl/te16_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// te16_back
// Output stage: encoder two and the result register.
// ----------------------------------------------------------------------------
module te16_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              stage_valid,
  output logic              stage_ready,
  input  te16_pkg::stage_t  stage,
  te16_out_if.source        result
);

  logic [te16_pkg::STATE_W-1:0] enc2_state;
  logic                         take;
  logic                         is_p2;

  // The result register takes a new item when empty or being emptied.
  assign stage_ready = !result.valid || result.ready;
  assign take        = stage_valid && stage_ready;
  assign is_p2       = (stage.kind == te16_pkg::KIND_PARITY2);

  // Result valid flag and encoder two.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      enc2_state   <= '0;
    end else begin
      if (stage_ready) begin
        result.valid <= stage_valid;
      end
      if (take && is_p2) begin
        enc2_state <= stage.block_end ? '0 :
                      te16_pkg::rsc_next(enc2_state, stage.data_bit);
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (take) begin
      result.kind           <= stage.kind;
      result.systematic_bit <= stage.data_bit;
      result.parity_bit     <= is_p2 ? te16_pkg::rsc_parity(enc2_state, stage.data_bit)
                                     : stage.parity_bit;
      result.block_end      <= stage.block_end;
    end
  end

endmodule

@@ hdl/te16_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// te16_checker
// Port-level checks of the turbo encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "turbo_encoder_rsc16_terminated_defines.svh"

module te16_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          feed_valid,
  input logic                          feed_ready,
  input logic [te16_pkg::MODE_W-1:0]   feed_mode,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic                          result_kind,
  input logic                          result_sys,
  input logic                          result_par,
  input logic                          result_end
);

  // No result is offered straight after reset.
  `TE16_ASSERT_RESET(a_reset_empty, rst, !result_valid, "result valid after reset")

  // A stalled result holds its item.
  `TE16_ASSERT_NEXT(a_stall_hold, result_valid && !result_ready, result_valid && $stable(result_kind) && $stable(result_sys) && $stable(result_par) && $stable(result_end), "stalled result item changed")

  // Input is refused only while the output side is stalled.
  `TE16_ASSERT_SAME(a_ready_stall, !feed_ready, result_valid && !result_ready, "input refused without an output stall")

  // A result that appears came from an accepted message or read item.
  `TE16_ASSERT_SAME(a_result_source, $rose(result_valid), $past(feed_valid && feed_ready && ((feed_mode == te16_pkg::MODE_MSG) || (feed_mode == te16_pkg::MODE_READ)), 2), "result without a matching item")

endmodule

bind turbo_encoder_rsc16_terminated te16_checker u_te16_checker (
  .clk          (clk),
  .rst          (rst),
  .feed_valid   (feed.valid),
  .feed_ready   (feed.ready),
  .feed_mode    (feed.mode),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_kind  (result.kind),
  .result_sys   (result.systematic_bit),
  .result_par   (result.parity_bit),
  .result_end   (result.block_end)
);

@@ bench/turbo_encoder_rsc16_terminated_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turbo_encoder_rsc16_terminated_tb
// Self-checking bench for the turbo encoder. It fills the interleaver and
// runs one full block so that every store entry holds a known value. It then
// applies a short directed set and random phases over many block lengths
// and both termination settings. Each result item is checked against a
// bit-level predictor of both encoders and the interleaver.
// ----------------------------------------------------------------------------
module turbo_encoder_rsc16_terminated_tb;
  import te16_pkg::*;

  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned RANDOM_ITEMS   = 800;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned NOISE_PCT      = 8;
  localparam int unsigned SHORT_MAX      = 40;

  // Mode three carries no operation; the encoder drops such items.
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  source_position;
    logic [POS_W-1:0]  target_position;
    logic              message_bit;
  } feed_item_t;

  typedef struct packed {
    kind_t kind;
    logic  systematic_bit;
    logic  parity_bit;
    logic  block_end;
  } coded_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  te16_in_if  feed();
  te16_out_if result();

  turbo_encoder_rsc16_terminated i_dut (
    .clk       (clk),
    .rst       (rst),
    .feed      (feed),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the configuration and the encoder state.
  logic [COUNT_W-1:0] len_reg;
  logic               term_reg;
  logic [STATE_W-1:0] enc1_state;
  logic [STATE_W-1:0] enc2_state;
  logic [COUNT_W-1:0] msg_count;
  logic [COUNT_W-1:0] read_count;
  logic [POS_W-1:0]   perm_table [BLOCK_MAX_DEF];
  logic               ilv_bits [BLOCK_MAX_DEF];

  feed_item_t  feed_backlog [$];
  coded_t      coded_expect [$];
  feed_item_t  shown_item;
  coded_t      oldest_coded;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned errors;
  int unsigned checked;
  int unsigned block_ends;
  int unsigned phases;
  int unsigned rand_items;
  int unsigned idle_cycles;

  // Clock with a 10 ns period.
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Works out the result of one accepted item and advances the predictor.
  function automatic void encode_item(input feed_item_t it);
    int unsigned        len;
    logic [STATE_W-1:0] s;
    logic               u;
    coded_t             c;
    len = (len_reg > BLOCK_MAX_DEF) ? BLOCK_MAX_DEF : len_reg;
    if (len == 0) len = 1;
    case (it.mode)
      MODE_LOAD: begin
        perm_table[it.source_position] = it.target_position;
      end
      MODE_MSG: begin
        s = enc1_state;
        u = it.message_bit;
        // Near the end of a terminated block the feedback bit is sent instead.
        if (term_reg && (msg_count + ENC_MEMORY >= len)) u = s[0] ^ s[3];
        if (msg_count < BLOCK_MAX_DEF) ilv_bits[perm_table[msg_count[POS_W-1:0]]] = u;
        c.kind           = KIND_PARITY1;
        c.systematic_bit = u;
        c.parity_bit     = u ^ s[0] ^ s[1] ^ s[2];
        c.block_end      = (msg_count + 1 >= len);
        if (c.block_end) begin
          enc1_state = '0;
          msg_count  = '0;
        end else begin
          enc1_state = {s[STATE_W-2:0], u ^ s[0] ^ s[3]};
          msg_count  = msg_count + 1'b1;
        end
        coded_expect.push_back(c);
      end
      MODE_READ: begin
        s = enc2_state;
        u = (read_count < BLOCK_MAX_DEF) ? ilv_bits[read_count[POS_W-1:0]] : 1'b0;
        c.kind           = KIND_PARITY2;
        c.systematic_bit = u;
        c.parity_bit     = u ^ s[0] ^ s[1] ^ s[2];
        c.block_end      = (read_count + 1 >= len);
        if (c.block_end) begin
          enc2_state = '0;
          read_count = '0;
        end else begin
          enc2_state = {s[STATE_W-2:0], u ^ s[0] ^ s[3]};
          read_count = read_count + 1'b1;
        end
        coded_expect.push_back(c);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic feed_item_t make_item(input logic [MODE_W-1:0] m,
                                           input int unsigned src,
                                           input int unsigned dst,
                                           input logic b);
    feed_item_t it;
    it.mode            = m;
    it.source_position = POS_W'(src);
    it.target_position = POS_W'(dst);
    it.message_bit     = b;
    return it;
  endfunction

  // Queues a random item of the given mode, now and then swapped for noise.
  task automatic queue_random(input logic [MODE_W-1:0] m);
    feed_item_t it;
    it = make_item(m, $urandom_range(0, BLOCK_MAX_DEF - 1),
                   $urandom_range(0, BLOCK_MAX_DEF - 1), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 99) < NOISE_PCT) it.mode = MODE_W'($urandom_range(0, 3));
    if (it.mode != MODE_IGNORED) rand_items++;
    feed_backlog.push_back(it);
  endtask

  // Waits until every item is accepted and every result has come back.
  task automatic drain();
    while (feed_backlog.size() != 0 || feed.valid || coded_expect.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers while the encoder is idle and moves to the next pace.
  task automatic write_cfg(input logic [COUNT_W-1:0] len, input logic term);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BLOCK_LENGTH;
    cfg_data  <= len;
    len_reg    = len;
    @(posedge clk);
    cfg_index <= CFG_TERMINATE;
    cfg_data  <= CFG_DATA_W'(term);
    term_reg   = term;
    @(posedge clk);
    cfg_we    <= 1'b0;
    phases++;
    case (phases % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 71;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 71;
      end
      default: begin
        send_idle_pct  = 17;
        recv_stall_pct = 17;
      end
    endcase
  endtask

  // Driver: shows queued items and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (rst) begin
      feed.valid <= 1'b0;
    end else begin
      if (feed.valid && feed.ready) encode_item(shown_item);
      if (!feed.valid || feed.ready) begin
        if (feed_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          shown_item            = feed_backlog.pop_front();
          feed.mode            <= shown_item.mode;
          feed.source_position <= shown_item.source_position;
          feed.target_position <= shown_item.target_position;
          feed.message_bit     <= shown_item.message_bit;
          feed.valid           <= 1'b1;
        end else begin
          feed.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result item against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (coded_expect.size() == 0) begin
          $error("Result item arrived with nothing expected");
          errors++;
        end else begin
          oldest_coded = coded_expect.pop_front();
          checked++;
          if (oldest_coded.block_end) block_ends++;
          if (result.kind !== oldest_coded.kind) begin
            $error("kind: expected %0d, got %0d", oldest_coded.kind, result.kind);
            errors++;
          end
          if (result.systematic_bit !== oldest_coded.systematic_bit) begin
            $error("systematic_bit: expected %0d, got %0d",
                   oldest_coded.systematic_bit, result.systematic_bit);
            errors++;
          end
          if (result.parity_bit !== oldest_coded.parity_bit) begin
            $error("parity_bit: expected %0d, got %0d",
                   oldest_coded.parity_bit, result.parity_bit);
            errors++;
          end
          if (result.block_end !== oldest_coded.block_end) begin
            $error("block_end: expected %0d, got %0d",
                   oldest_coded.block_end, result.block_end);
            errors++;
          end
        end
      end
      result.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if ((feed.valid && feed.ready) || (result.valid && result.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned perm [BLOCK_MAX_DEF];
    int unsigned j;
    int unsigned tmp;
    int unsigned len;
    int unsigned eff;
    int unsigned blocks;
    logic        term;

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = CFG_BLOCK_LENGTH;
    cfg_data             = '0;
    feed.valid           = 1'b0;
    feed.mode            = MODE_LOAD;
    feed.source_position = '0;
    feed.target_position = '0;
    feed.message_bit     = 1'b0;
    result.ready         = 1'b0;
    len_reg              = LEN_RESET;
    term_reg             = 1'b1;
    enc1_state           = '0;
    enc2_state           = '0;
    msg_count            = '0;
    read_count           = '0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    errors               = 0;
    checked              = 0;
    block_ends           = 0;
    phases               = 0;
    rand_items           = 0;
    idle_cycles          = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole interleaver with a shuffled mapping and run one full
    // block at the reset settings, so every store entry is known afterwards.
    for (int i = 0; i < BLOCK_MAX_DEF; i++) perm[i] = i;
    for (int i = BLOCK_MAX_DEF - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < BLOCK_MAX_DEF; i++)
      feed_backlog.push_back(make_item(MODE_LOAD, i, perm[i], 1'b0));
    for (int i = 0; i < BLOCK_MAX_DEF; i++)
      feed_backlog.push_back(make_item(MODE_MSG, 0, 0, 1'($urandom_range(0, 1))));
    for (int i = 0; i < BLOCK_MAX_DEF; i++)
      feed_backlog.push_back(make_item(MODE_READ, 0, 0, 1'b0));

    // A length of zero acts as one, and termination forces every bit.
    write_cfg(8'd0, 1'b1);
    feed_backlog.push_back(make_item(MODE_MSG, 0, 0, 1'b1));
    feed_backlog.push_back(make_item(MODE_MSG, 0, 0, 1'b0));
    feed_backlog.push_back(make_item(MODE_READ, 0, 0, 1'b0));
    feed_backlog.push_back(make_item(MODE_READ, 0, 0, 1'b0));
    feed_backlog.push_back(make_item(MODE_IGNORED, BLOCK_MAX_DEF - 1,
                                     BLOCK_MAX_DEF - 1, 1'b1));

    // Oversized length saturates; loads at the position extremes, with a
    // duplicate target; a block left part-way through.
    write_cfg(8'd255, 1'b0);
    feed_backlog.push_back(make_item(MODE_LOAD, 0, BLOCK_MAX_DEF - 1, 1'b0));
    feed_backlog.push_back(make_item(MODE_LOAD, BLOCK_MAX_DEF - 1, 0, 1'b0));
    feed_backlog.push_back(make_item(MODE_LOAD, 1, BLOCK_MAX_DEF - 1, 1'b0));
    feed_backlog.push_back(make_item(MODE_MSG, 0, 0, 1'b1));
    feed_backlog.push_back(make_item(MODE_MSG, 0, 0, 1'b1));
    feed_backlog.push_back(make_item(MODE_MSG, 0, 0, 1'b0));
    for (int i = 0; i < 3; i++) feed_backlog.push_back(make_item(MODE_READ, 0, 0, 1'b0));

    // The length shrinks to one above the running counts, so the next bit ends the
    // block; then a block short enough that every bit is forced.
    write_cfg(8'd4, 1'b1);
    for (int i = 0; i < 5; i++) feed_backlog.push_back(make_item(MODE_MSG, 0, 0, 1'b1));
    feed_backlog.push_back(make_item(MODE_READ, 0, 0, 1'b0));

    // Random phases: mostly whole blocks of message bits followed by their
    // read-out, with occasional reloads of the interleaver and some noise.
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       len = BLOCK_MAX_DEF;
        1:       len = $urandom_range(BLOCK_MAX_DEF + 1, 255);
        2:       len = $urandom_range(0, 5);
        default: len = $urandom_range(6, SHORT_MAX);
      endcase
      term = 1'($urandom_range(0, 1));
      write_cfg(COUNT_W'(len), term);
      eff    = (len > BLOCK_MAX_DEF) ? BLOCK_MAX_DEF : ((len == 0) ? 1 : len);
      blocks = (eff > SHORT_MAX) ? 1 : $urandom_range(1, 3);
      if ($urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 8)) queue_random(MODE_LOAD);
      repeat (blocks) begin
        repeat (eff) queue_random(MODE_MSG);
        repeat (eff) queue_random(MODE_READ);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d result items, %0d of them block ends, over %0d settings.",
             checked, block_ends, phases);
    $display("Random part: %0d items over lengths 0 to 255, termination on and off.",
             rand_items);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
